>>> design/swq_pkg.sv
// Shared types and constants for the semaphore wait queue table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package swq_pkg;

  typedef enum logic [1:0] {
    OP_BLOCK   = 2'd0,
    OP_UNBLOCK = 2'd1,
    OP_CANCEL  = 2'd2,
    OP_PEEK    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_FULL = 2'd1,
    STS_NONE = 2'd2,
    STS_DUP  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MATCH,
    BK_EXEC,
    BK_UNLINK
  } back_state_e;

  localparam int unsigned PidBits = 5;

  typedef struct packed {
    op_e                op;
    logic [PidBits-1:0] pid;
    logic               pid_ok;
  } req_t;

endpackage
`default_nettype wire

>>> design/semaphore_wait_queue_table_top.sv
// Semaphore wait queue table: each request passes the back-end sequencer (pop, match,
// execute, unlink); block, peek and a failed unblock or cancel skip the unlink step.
// One request is in the back end at a time; a two-entry queue absorbs bursts.
// Results pulse done_o for one cycle; the receiver cannot stall.
// Reset frees all descriptors and unblocks all processes at once; no clearing pass.
// Depends on swq_pkg, swq_front, swq_fifo, swq_back.
`timescale 1ns / 1ps
`default_nettype none
module semaphore_wait_queue_table_top #(
  parameter int unsigned MAX_PROCS = 32,
  parameter int unsigned KEY_BITS  = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  operation_i,
  input  wire logic [31:0] sem_key_i,
  input  wire logic [4:0]  proc_id_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [4:0]       proc_out_o
);

  localparam int unsigned KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int unsigned QW = $bits(swq_pkg::req_t) + KW;

  logic           push, pop, q_empty, q_full;
  swq_pkg::req_t  f_req, b_req;
  logic [KW-1:0]  f_key, b_key;
  logic [QW-1:0]  q_out;

  swq_front #(.MAX_PROCS(MAX_PROCS), .KW(KW)) u_front (
    .start       (start),
    .q_full_i    (q_full),
    .operation_i (operation_i),
    .sem_key_i   (sem_key_i),
    .proc_id_i   (proc_id_i),
    .busy        (busy),
    .push_o      (push),
    .req_o       (f_req),
    .key_o       (f_key)
  );

  swq_fifo #(.W(QW)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_req, f_key}),
    .pop_i   (pop),
    .data_o  (q_out),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  assign b_req = swq_pkg::req_t'(q_out[QW-1:KW]);
  assign b_key = q_out[KW-1:0];

  swq_back #(.MAX_PROCS(MAX_PROCS), .KW(KW)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_req_i    (b_req),
    .q_key_i    (b_key),
    .pop_o      (pop),
    .done_o     (done_o),
    .status_o   (status_o),
    .proc_out_o (proc_out_o)
  );

endmodule
`default_nettype wire

>>> design/swq_front.sv
// Front end: accepts requests, decodes the operation and range-checks the process.
// Depends on swq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module swq_front #(
  parameter int unsigned MAX_PROCS = 32,
  parameter int unsigned KW        = 32
) (
  input  wire logic                         start,
  input  wire logic                         q_full_i,
  input  wire logic [1:0]                   operation_i,
  input  wire logic [31:0]                  sem_key_i,
  input  wire logic [swq_pkg::PidBits-1:0]  proc_id_i,
  output logic                              busy,
  output logic                              push_o,
  output swq_pkg::req_t                     req_o,
  output logic [KW-1:0]                     key_o
);

  always_comb begin
    busy        = q_full_i;
    push_o      = start && !q_full_i;
    req_o.op    = swq_pkg::op_e'(operation_i);
    req_o.pid   = proc_id_i;
    req_o.pid_ok = (32'(proc_id_i) < MAX_PROCS);
    key_o       = sem_key_i[KW-1:0];
  end

endmodule
`default_nettype wire

>>> design/swq_fifo.sv
// Two-entry request queue between front and back end.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module swq_fifo #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  input  wire logic         pop_i,
  output logic [W-1:0]      data_o,
  output logic              empty_o,
  output logic              full_o
);

  logic [W-1:0] mem_q [2];
  logic         wp_q, wp_d, rp_q, rp_d;
  logic [1:0]   cnt_q, cnt_d;

  always_comb begin
    wp_d  = push_i ? ~wp_q : wp_q;
    rp_d  = pop_i ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
    data_o  = mem_q[rp_q];
    empty_o = (cnt_q == 2'd0);
    full_o  = (cnt_q == 2'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

>>> design/swq_back.sv
// Back end: key match, descriptor pool and linked wait queues; one result per request.
// Depends on swq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module swq_back #(
  parameter int unsigned MAX_PROCS = 32,
  parameter int unsigned KW        = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        q_empty_i,
  input  wire swq_pkg::req_t               q_req_i,
  input  wire logic [KW-1:0]               q_key_i,
  output logic                             pop_o,
  output logic                             done_o,
  output logic [1:0]                       status_o,
  output logic [swq_pkg::PidBits-1:0]      proc_out_o
);

  localparam int unsigned PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

  swq_pkg::back_state_e state_q, state_d;

  swq_pkg::req_t  req_q;
  logic [KW-1:0]  key_q;
  logic [PW-1:0]  pid_idx;

  logic           desc_valid_q   [MAX_PROCS];
  logic [KW-1:0]  desc_key_q     [MAX_PROCS];
  logic [PW-1:0]  desc_head_q    [MAX_PROCS];
  logic [PW-1:0]  desc_tail_q    [MAX_PROCS];
  logic [PW-1:0]  proc_next_q    [MAX_PROCS];
  logic [PW-1:0]  proc_prev_q    [MAX_PROCS];
  logic           proc_blocked_q [MAX_PROCS];
  logic [PW-1:0]  proc_desc_q    [MAX_PROCS];

  logic [MAX_PROCS-1:0] match_q, free_q;
  logic                 blk_q;
  logic [PW-1:0]        unl_q;

  logic                 hit, has_free;
  logic [PW-1:0]        hit_idx, free_idx;

  logic                 res_vld_q, res_vld_d;
  logic [1:0]           res_sts_q, res_sts_d;
  logic [PW-1:0]        res_proc_q, res_proc_d;

  logic                 do_add, do_new, do_unlink, go_unlink;
  logic [PW-1:0]        unl_d;

  logic [PW-1:0]        u_desc, u_head, u_tail, u_next, u_prev;

  assign pid_idx = PW'(req_q.pid);

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    has_free = 1'b0;
    free_idx = '0;
    for (int i = MAX_PROCS - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        hit     = 1'b1;
        hit_idx = PW'(i);
      end
      if (free_q[i]) begin
        has_free = 1'b1;
        free_idx = PW'(i);
      end
    end
  end

  assign u_desc = proc_desc_q[unl_q];
  assign u_head = desc_head_q[u_desc];
  assign u_tail = desc_tail_q[u_desc];
  assign u_next = proc_next_q[unl_q];
  assign u_prev = proc_prev_q[unl_q];

  always_comb begin
    state_d    = state_q;
    pop_o      = 1'b0;
    res_vld_d  = 1'b0;
    res_sts_d  = swq_pkg::STS_NONE;
    res_proc_d = '0;
    do_add     = 1'b0;
    do_new     = 1'b0;
    do_unlink  = 1'b0;
    go_unlink  = 1'b0;
    unl_d      = unl_q;
    unique case (state_q)
      swq_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          state_d = swq_pkg::BK_MATCH;
        end
      end
      swq_pkg::BK_MATCH: begin
        state_d = swq_pkg::BK_EXEC;
      end
      swq_pkg::BK_EXEC: begin
        state_d   = swq_pkg::BK_IDLE;
        res_vld_d = 1'b1;
        unique case (req_q.op)
          swq_pkg::OP_BLOCK: begin
            if (!req_q.pid_ok) begin
              res_sts_d = swq_pkg::STS_NONE;
            end else if (blk_q) begin
              res_sts_d = swq_pkg::STS_DUP;
            end else if (hit) begin
              do_add     = 1'b1;
              res_sts_d  = swq_pkg::STS_OK;
              res_proc_d = pid_idx;
            end else if (has_free) begin
              do_new     = 1'b1;
              res_sts_d  = swq_pkg::STS_OK;
              res_proc_d = pid_idx;
            end else begin
              res_sts_d = swq_pkg::STS_FULL;
            end
          end
          swq_pkg::OP_UNBLOCK: begin
            if (hit) begin
              go_unlink = 1'b1;
              unl_d     = desc_head_q[hit_idx];
            end
          end
          swq_pkg::OP_CANCEL: begin
            if (req_q.pid_ok && blk_q) begin
              go_unlink = 1'b1;
              unl_d     = pid_idx;
            end
          end
          swq_pkg::OP_PEEK: begin
            if (hit) begin
              res_sts_d  = swq_pkg::STS_OK;
              res_proc_d = desc_head_q[hit_idx];
            end
          end
          default: ;
        endcase
        if (go_unlink) begin
          res_vld_d = 1'b0;
          state_d   = swq_pkg::BK_UNLINK;
        end
      end
      swq_pkg::BK_UNLINK: begin
        do_unlink  = 1'b1;
        res_vld_d  = 1'b1;
        res_sts_d  = swq_pkg::STS_OK;
        res_proc_d = unl_q;
        state_d    = swq_pkg::BK_IDLE;
      end
      default: state_d = swq_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= swq_pkg::BK_IDLE;
      res_vld_q <= 1'b0;
      for (int i = 0; i < MAX_PROCS; i++) begin
        desc_valid_q[i]   <= 1'b0;
        proc_blocked_q[i] <= 1'b0;
      end
    end else begin
      state_q   <= state_d;
      res_vld_q <= res_vld_d;
      if (do_add) begin
        proc_blocked_q[pid_idx] <= 1'b1;
      end
      if (do_new) begin
        proc_blocked_q[pid_idx] <= 1'b1;
        desc_valid_q[free_idx]  <= 1'b1;
      end
      if (do_unlink) begin
        proc_blocked_q[unl_q] <= 1'b0;
        if (u_head == unl_q && u_tail == unl_q) begin
          desc_valid_q[u_desc] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_sts_q  <= res_sts_d;
    res_proc_q <= res_proc_d;
    unl_q      <= unl_d;
    if (pop_o) begin
      req_q <= q_req_i;
      key_q <= q_key_i;
    end
    if (state_q == swq_pkg::BK_MATCH) begin
      for (int i = 0; i < MAX_PROCS; i++) begin
        match_q[i] <= desc_valid_q[i] && (desc_key_q[i] == key_q);
        free_q[i]  <= !desc_valid_q[i];
      end
      blk_q <= proc_blocked_q[pid_idx];
    end
    if (do_add) begin
      proc_next_q[desc_tail_q[hit_idx]] <= pid_idx;
      proc_prev_q[pid_idx]              <= desc_tail_q[hit_idx];
      desc_tail_q[hit_idx]              <= pid_idx;
      proc_desc_q[pid_idx]              <= hit_idx;
    end
    if (do_new) begin
      desc_key_q[free_idx]  <= key_q;
      desc_head_q[free_idx] <= pid_idx;
      desc_tail_q[free_idx] <= pid_idx;
      proc_desc_q[pid_idx]  <= free_idx;
    end
    if (do_unlink) begin
      if (u_head == unl_q && u_tail == unl_q) begin
      end else if (u_head == unl_q) begin
        desc_head_q[u_desc] <= u_next;
      end else if (u_tail == unl_q) begin
        desc_tail_q[u_desc] <= u_prev;
      end else begin
        proc_next_q[u_prev] <= u_next;
        proc_prev_q[u_next] <= u_prev;
      end
    end
  end

  assign done_o     = res_vld_q;
  assign status_o   = res_sts_q;
  assign proc_out_o = swq_pkg::PidBits'(res_proc_q);

endmodule
`default_nettype wire

>>> sim/tb.sv
// Testbench for semaphore_wait_queue_table_top: random and directed requests
// checked against a behavioral model of the descriptor pool and wait queues.
// Depends on swq_pkg and the design sources.
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    swq_pkg::op_e op;
    logic [31:0]  key;
    logic [4:0]   pid;
  } sem_req_t;

  typedef struct packed {
    swq_pkg::status_e sts;
    logic [4:0]       pout;
  } sem_rsp_t;

  localparam int NPROC = 32;
  localparam int STALL_LIMIT = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic [1:0]  operation_i = '0;
  logic [31:0] sem_key_i = '0;
  logic [4:0]  proc_id_i = '0;
  logic        busy, done_o;
  logic [1:0]  status_o;
  logic [4:0]  proc_out_o;

  semaphore_wait_queue_table_top DUT (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .sem_key_i, .proc_id_i,
    .done_o, .status_o, .proc_out_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Wait-queue model: per key an ordered list of process ids.
  logic        pool_used [NPROC];
  logic [31:0] pool_key [NPROC];
  logic [4:0]  pool_q [NPROC][$];
  logic        pid_waiting [NPROC];

  sem_req_t pending_reqs[$];
  sem_rsp_t expected_rsps[$];
  int errors = 0;
  int idle_pct = 30;
  bit hold_off = 0;
  bit in_taken = 0;
  int quiet_cycles = 0;

  function automatic int find_slot(logic [31:0] k);
    for (int d = 0; d < NPROC; d++)
      if (pool_used[d] && pool_key[d] == k) return d;
    return -1;
  endfunction

  function automatic void drop_pid(logic [4:0] p);
    for (int d = 0; d < NPROC; d++) begin
      if (!pool_used[d]) continue;
      for (int i = 0; i < pool_q[d].size(); i++)
        if (pool_q[d][i] == p) begin
          pool_q[d].delete(i);
          if (pool_q[d].size() == 0) pool_used[d] = 0;
          pid_waiting[p] = 0;
          return;
        end
    end
  endfunction

  function automatic sem_rsp_t predict_queue_op(sem_req_t r);
    sem_rsp_t o;
    int d;
    o.sts = swq_pkg::STS_NONE;
    o.pout = '0;
    case (r.op)
      swq_pkg::OP_BLOCK: begin
        if (pid_waiting[r.pid]) o.sts = swq_pkg::STS_DUP;
        else begin
          d = find_slot(r.key);
          if (d < 0) begin
            for (d = 0; d < NPROC && pool_used[d]; d++) ;
            if (d < NPROC) begin
              pool_used[d] = 1;
              pool_key[d] = r.key;
              pool_q[d] = {};
            end else d = -1;
          end
          if (d < 0) o.sts = swq_pkg::STS_FULL;
          else begin
            pool_q[d].push_back(r.pid);
            pid_waiting[r.pid] = 1;
            o.sts = swq_pkg::STS_OK;
            o.pout = r.pid;
          end
        end
      end
      swq_pkg::OP_UNBLOCK: begin
        d = find_slot(r.key);
        if (d >= 0) begin
          o.sts = swq_pkg::STS_OK;
          o.pout = pool_q[d][0];
          drop_pid(o.pout);
        end
      end
      swq_pkg::OP_CANCEL: begin
        if (pid_waiting[r.pid]) begin
          o.sts = swq_pkg::STS_OK;
          o.pout = r.pid;
          drop_pid(r.pid);
        end
      end
      default: begin
        d = find_slot(r.key);
        if (d >= 0) begin
          o.sts = swq_pkg::STS_OK;
          o.pout = pool_q[d][0];
        end
      end
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void add_req(swq_pkg::op_e op, logic [31:0] k, logic [4:0] p);
    sem_req_t r;
    r.op = op;
    r.key = k;
    r.pid = p;
    pending_reqs.push_back(r);
  endfunction

  // Driver: present the next request at the falling edge; hold one not yet taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!start || in_taken)) begin
      if (pending_reqs.size() > 0 && !hold_off && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        operation_i <= pending_reqs[0].op;
        sem_key_i <= pending_reqs[0].key;
        proc_id_i <= pending_reqs[0].pid;
        pending_reqs.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: accept requests and results at the rising edge.
  always @(posedge clk_i) begin
    sem_req_t r;
    sem_rsp_t w;
    if (rst_ni) begin
      in_taken <= start && !busy;
      if ((start && !busy) || done_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (start && !busy) begin
        r.op = swq_pkg::op_e'(operation_i);
        r.key = sem_key_i;
        r.pid = proc_id_i;
        expected_rsps.push_back(predict_queue_op(r));
      end
      if (done_o) begin
        if (expected_rsps.size() == 0) report_mismatch("unexpected result", status_o, -1);
        else begin
          w = expected_rsps.pop_front();
          if (status_o !== w.sts) report_mismatch("status", status_o, w.sts);
          if (proc_out_o !== w.pout) report_mismatch("proc_out", proc_out_o, w.pout);
        end
      end
      if (quiet_cycles > STALL_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_key();
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF;
      2: return 32'h0;
      default: return 32'h1000 + $urandom_range(11) * 32'h0101_0101;
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < NPROC; i++) begin
      pool_used[i] = 0;
      pid_waiting[i] = 0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    add_req(swq_pkg::OP_PEEK, 32'h0, 5'd0);
    add_req(swq_pkg::OP_UNBLOCK, 32'hFFFF_FFFF, 5'd0);
    add_req(swq_pkg::OP_CANCEL, 32'h5, 5'd31);
    add_req(swq_pkg::OP_BLOCK, 32'hFFFF_FFFF, 5'd31);
    add_req(swq_pkg::OP_BLOCK, 32'hFFFF_FFFF, 5'd0);
    add_req(swq_pkg::OP_BLOCK, 32'h0, 5'd31);
    add_req(swq_pkg::OP_BLOCK, 32'hFFFF_FFFF, 5'd7);
    add_req(swq_pkg::OP_PEEK, 32'hFFFF_FFFF, 5'd3);
    add_req(swq_pkg::OP_CANCEL, 32'h0, 5'd0);
    add_req(swq_pkg::OP_UNBLOCK, 32'hFFFF_FFFF, 5'd9);
    add_req(swq_pkg::OP_UNBLOCK, 32'hFFFF_FFFF, 5'd9);
    add_req(swq_pkg::OP_PEEK, 32'hFFFF_FFFF, 5'd0);
    add_req(swq_pkg::OP_CANCEL, 32'h0, 5'd31);
    // fill the pool with distinct keys
    for (int p = 0; p < NPROC; p++) add_req(swq_pkg::OP_BLOCK, 32'hA000_0000 + p, p[4:0]);
    wait_drained();
    for (int p = 0; p < NPROC; p++) add_req(swq_pkg::OP_CANCEL, $urandom(), p[4:0]);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 30 : (ph == 1) ? 64 : 0;
      for (int n = 0; n < 420; n++)
        add_req(swq_pkg::op_e'($urandom_range(3)), pick_key(), 5'($urandom_range(31)));
      if (ph == 0) begin
        while (pending_reqs.size() > 200) @(posedge clk_i);
        hold_off = 1;
        while (start || expected_rsps.size() > 0) @(posedge clk_i);
        hold_off = 0;
      end
      wait_drained();
    end
    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule
